### src/mandelbrot_escape_time_pixel_defines.svh
// Assertion macros for the Mandelbrot escape-time pixel engine.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MET_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define MET_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/met_pkg.sv
// Shared types and constants for the Mandelbrot escape-time pixel engine.
// Used by met_core and mandelbrot_escape_time_pixel; no dependencies.
`timescale 1ns / 1ps

package met_pkg;

	localparam int FRAC_BITS  = 28;
	localparam int COORD_BITS = 12;
	localparam int CNT_W      = 11;
	localparam int TAB_AW     = 10;
	localparam int COLOR_W    = 32;
	localparam int REG_W      = 32;
	localparam int REG_IDX_W  = 3;
	// Coordinate product: signed register times zero-extended pixel index.
	localparam int CPROD_W    = REG_W + COORD_BITS + 1;
	// Iterate width: holds c plus one update before the magnitude check escapes.
	localparam int ZW         = CPROD_W + 3;
	// Multiplier operand width: values below two in magnitude.
	localparam int MULW       = FRAC_BITS + 2;
	localparam int PROD_W     = 2 * MULW;
	localparam int SQ_W       = PROD_W - FRAC_BITS;
	localparam int MAG_W      = SQ_W + 1;

	localparam logic [CNT_W-1:0]   MAX_ITER     = CNT_W'(1024);
	localparam logic [COLOR_W-1:0] INSIDE_COLOR = 32'hFF00_0000;
	localparam logic signed [ZW-1:0] TWO_Q      = ZW'(2) <<< FRAC_BITS;
	localparam logic [MAG_W-1:0]   FOUR_Q       = MAG_W'(4) << FRAC_BITS;

	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_COMPUTE = 1'b1;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ORIGIN_REAL = 3'd0,
		REG_ORIGIN_IMAG = 3'd1,
		REG_STEP_REAL   = 3'd2,
		REG_STEP_IMAG   = 3'd3,
		REG_MAX_DEPTH   = 3'd4
	} met_reg_t;

	typedef struct packed {
		logic [REG_W-1:0] origin_real;
		logic [REG_W-1:0] origin_imag;
		logic [REG_W-1:0] step_real;
		logic [REG_W-1:0] step_imag;
		logic [CNT_W-1:0] max_depth;
	} met_cfg_t;

	typedef struct packed {
		logic             done;
		logic             in_set;
		logic [CNT_W-1:0] depth;
	} met_res_t;

	typedef enum logic [1:0] {
		TOP_IDLE,
		TOP_BUSY,
		TOP_READ,
		TOP_SEND
	} met_top_state_t;

	typedef enum logic [2:0] {
		CORE_IDLE,
		CORE_MUL,
		CORE_ADD,
		CORE_SQ,
		CORE_UPD
	} met_core_state_t;

endpackage

### src/mandelbrot_escape_time_pixel.sv
// A load word writes the color table; a compute word occupies the engine until its
// result word has entered the output register.
// Throughput: one pixel at a time, iterating on shared multipliers;
// the next word can be accepted once the result is in the output register.
// Reset clears control state and restores the register defaults; the color
// table keeps its contents and must be loaded before use.
`timescale 1ns / 1ps
`include "mandelbrot_escape_time_pixel_defines.svh"

module mandelbrot_escape_time_pixel import met_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [71:0]          s_tdata,   // pixel_x, pixel_y, entry_index, entry_color, zero pad
	input  logic [0:0]           s_tuser,   // action
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [47:0]          m_tdata,   // color, iterations, zero pad
	output logic [0:0]           m_tuser,   // inside_res
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data
);

	met_top_state_t state_q, state_d;
	met_cfg_t       cfg_q;
	met_res_t       res;

	logic [COLOR_W-1:0] table_mem [2**TAB_AW];
	logic [COLOR_W-1:0] rd_data_q;

	logic [CNT_W-1:0]   depth_q;
	logic               inside_q;
	logic               out_valid_q, out_inside_q;
	logic [COLOR_W-1:0] out_color_q;
	logic [CNT_W-1:0]   out_iter_q;

	logic accept, wr_en, start, load_out;

	assign s_tready  = (state_q == TOP_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;
	assign wr_en     = accept && (s_tuser[0] == ACT_LOAD);
	assign start     = accept && (s_tuser[0] == ACT_COMPUTE);
	assign load_out  = (state_q == TOP_SEND) && (!out_valid_q || m_tready);

	met_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.px     (s_tdata[11:0]),
		.py     (s_tdata[23:12]),
		.cfg    (cfg_q),
		.res    (res)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			TOP_IDLE: if (start) state_d = TOP_BUSY;
			TOP_BUSY: if (res.done) state_d = TOP_READ;
			TOP_READ: state_d = TOP_SEND;
			TOP_SEND: if (load_out) state_d = TOP_IDLE;
			default:  state_d = TOP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= TOP_IDLE;
			out_valid_q <= 1'b0;
			depth_q     <= '0;
			inside_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == TOP_BUSY && res.done) begin
				depth_q  <= res.depth;
				inside_q <= res.in_set;
			end
			if (load_out) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_real <= 32'hE000_0000;
			cfg_q.origin_imag <= 32'hE800_0000;
			cfg_q.step_real   <= 32'd787201;
			cfg_q.step_imag   <= 32'd787201;
			cfg_q.max_depth   <= MAX_ITER;
		end else if (cfg_valid && cfg_ready) begin
			case (met_reg_t'(cfg_index))
				REG_ORIGIN_REAL: cfg_q.origin_real <= cfg_data;
				REG_ORIGIN_IMAG: cfg_q.origin_imag <= cfg_data;
				REG_STEP_REAL:   cfg_q.step_real   <= cfg_data;
				REG_STEP_IMAG:   cfg_q.step_imag   <= cfg_data;
				REG_MAX_DEPTH:   cfg_q.max_depth   <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) table_mem[s_tdata[33:24]] <= s_tdata[65:34];
		rd_data_q <= table_mem[depth_q[TAB_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_color_q  <= inside_q ? INSIDE_COLOR : rd_data_q;
			out_iter_q   <= depth_q;
			out_inside_q <= inside_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_iter_q, out_color_q};
	assign m_tuser  = out_inside_q;

	`MET_ASSERT_NOW(a_inside_black, m_tvalid && m_tuser[0], m_tdata[31:0] == INSIDE_COLOR, "inside result is not opaque black")
	`MET_ASSERT_NOW(a_iter_bound, m_tvalid, m_tdata[42:32] <= MAX_ITER, "iteration count above the limit")
	`MET_ASSERT_NOW(a_done_busy, res.done, state_q == TOP_BUSY, "core finished while no pixel was pending")
	`MET_ASSERT_NEXT(a_start_busy, start, state_q == TOP_BUSY && !s_tready, "compute word did not occupy the engine")

endmodule

### src/met_core.sv
// Escape-time iteration datapath: forms c from the pixel index and iterates
// z = z^2 + c on one shared set of three multipliers. Depends on met_pkg.
`timescale 1ns / 1ps

module met_core import met_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [COORD_BITS-1:0] px,
	input  logic [COORD_BITS-1:0] py,
	input  met_cfg_t              cfg,
	output met_res_t              res
);

	met_core_state_t state_q, state_d;

	logic [COORD_BITS-1:0]    px_q, py_q;
	logic signed [CPROD_W-1:0] prod_r_q, prod_i_q;
	logic signed [ZW-1:0]     cr_q, ci_q, zr_q, zi_q;
	logic signed [PROD_W-1:0] sq_r_q, sq_i_q, cross_q;
	logic [CNT_W-1:0]         depth_q, limit;
	logic                     inside_q, done_q;

	logic signed [ZW-1:0]     cr_d, ci_d, zr2_w, zi2_w, cross_w;
	logic signed [MULW-1:0]   zr_m, zi_m;
	logic [MAG_W-1:0]         mag;
	logic                     at_limit, big, esc_sq;

	assign limit    = (cfg.max_depth > MAX_ITER) ? MAX_ITER : cfg.max_depth;
	assign at_limit = (depth_q == limit);
	assign big      = (zr_q >= TWO_Q) || (zr_q <= -TWO_Q) ||
			  (zi_q >= TWO_Q) || (zi_q <= -TWO_Q);
	assign zr_m     = zr_q[MULW-1:0];
	assign zi_m     = zi_q[MULW-1:0];

	assign cr_d    = ZW'($signed(cfg.origin_real)) + ZW'(prod_r_q);
	assign ci_d    = ZW'($signed(cfg.origin_imag)) + ZW'(prod_i_q);
	assign zr2_w   = ZW'(sq_r_q[PROD_W-1:FRAC_BITS]);
	assign zi2_w   = ZW'(sq_i_q[PROD_W-1:FRAC_BITS]);
	assign mag     = MAG_W'(sq_r_q[PROD_W-1:FRAC_BITS]) + MAG_W'(sq_i_q[PROD_W-1:FRAC_BITS]);
	assign esc_sq  = (mag >= FOUR_Q);
	assign cross_w = ZW'(cross_q >>> (FRAC_BITS - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			CORE_IDLE: if (start) state_d = CORE_MUL;
			CORE_MUL:  state_d = CORE_ADD;
			CORE_ADD:  state_d = CORE_SQ;
			CORE_SQ: begin
				if (at_limit || big) state_d = CORE_IDLE;
				else state_d = CORE_UPD;
			end
			CORE_UPD: begin
				if (esc_sq) state_d = CORE_IDLE;
				else state_d = CORE_SQ;
			end
			default: state_d = CORE_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= CORE_IDLE;
			done_q   <= 1'b0;
			inside_q <= 1'b0;
			depth_q  <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			case (state_q)
				CORE_ADD: depth_q <= '0;
				CORE_SQ: begin
					if (at_limit || big) begin
						done_q   <= 1'b1;
						inside_q <= at_limit;
					end
				end
				CORE_UPD: begin
					if (esc_sq) begin
						done_q   <= 1'b1;
						inside_q <= 1'b0;
					end else begin
						depth_q <= depth_q + CNT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			CORE_IDLE: begin
				if (start) begin
					px_q <= px;
					py_q <= py;
				end
			end
			CORE_MUL: begin
				prod_r_q <= $signed(cfg.step_real) * $signed({1'b0, px_q});
				prod_i_q <= $signed(cfg.step_imag) * $signed({1'b0, py_q});
			end
			CORE_ADD: begin
				cr_q <= cr_d;
				ci_q <= ci_d;
				zr_q <= cr_d;
				zi_q <= ci_d;
			end
			CORE_SQ: begin
				sq_r_q  <= zr_m * zr_m;
				sq_i_q  <= zi_m * zi_m;
				cross_q <= zr_m * zi_m;
			end
			CORE_UPD: begin
				zr_q <= zr2_w - zi2_w + cr_q;
				zi_q <= cross_w + ci_q;
			end
			default: ;
		endcase
	end

	assign res = '{done: done_q, in_set: inside_q, depth: depth_q};

endmodule
